// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of this block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fftc_pkg.sv =====
`default_nettype none

package fftc_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_HALF = 256;
  localparam int IDX_W    = $clog2(MAX_HALF);
  localparam int LEN_W    = $clog2(MAX_HALF + 1);

  // Sample, product and result widths.
  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int FRAC_W = 15;
  localparam int SUM_W  = PROD_W + 1;
  localparam int OUT_W  = 18;
  localparam int RND    = 1 << (FRAC_W - 1);

  // Input item kinds.
  typedef enum logic {
    MODE_DATA    = 1'b0,
    MODE_TWIDDLE = 1'b1
  } mode_t;

  // One complex sample or twiddle.
  typedef struct packed {
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
  } cplx_t;

  // Position information that travels with a pair.
  typedef struct packed {
    logic [IDX_W-1:0] pair_index;
    logic             group_end;
  } tag_t;

endpackage

`default_nettype wire

// ===== design/fftc_bfly.sv =====
`default_nettype none

// Butterfly datapath: a product stage followed by the combine and result register.
module fftc_bfly (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_vld,
  output logic                                 in_rdy,
  input  fftc_pkg::cplx_t                      in_a,
  input  fftc_pkg::cplx_t                      in_b,
  input  fftc_pkg::cplx_t                      in_w,
  input  fftc_pkg::tag_t                       in_tag,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_top_re,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_top_im,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_bottom_re,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_bottom_im,
  output logic [fftc_pkg::IDX_W-1:0]           out_pair_index,
  output logic                                 out_group_end
);

  logic                                   prod_v_r, prod_v_nxt;
  logic                                   res_v_r, res_v_nxt;
  logic                                   res_rdy;
  logic signed [fftc_pkg::PROD_W-1:0]     p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  fftc_pkg::cplx_t                        a2_r;
  fftc_pkg::tag_t                         tag2_r;
  logic signed [fftc_pkg::SUM_W-1:0]      sum_re, sum_im;
  logic signed [fftc_pkg::OUT_W-1:0]      t_re, t_im, a_re, a_im;
  logic signed [fftc_pkg::OUT_W-1:0]      top_re_r, top_im_r, bot_re_r, bot_im_r;
  fftc_pkg::tag_t                         tag3_r;

  // Each stage moves on when the one after it is empty or draining.
  always_comb begin
    res_rdy    = !res_v_r || !out_stall;
    in_rdy     = !prod_v_r || res_rdy;
    prod_v_nxt = in_rdy ? in_vld : prod_v_r;
    res_v_nxt  = res_rdy ? prod_v_r : res_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      res_v_r  <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
      res_v_r  <= res_v_nxt;
    end
  end

  // Product stage: the four partial products of b times w.
  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      p_rr_r <= in_b.re * in_w.re;
      p_ii_r <= in_b.im * in_w.im;
      p_ir_r <= in_b.im * in_w.re;
      p_ri_r <= in_b.re * in_w.im;
      a2_r   <= in_a;
      tag2_r <= in_tag;
    end
  end

  // Combine the products, round half up and drop the fraction bits.
  always_comb begin
    sum_re = fftc_pkg::SUM_W'(p_rr_r) - fftc_pkg::SUM_W'(p_ii_r)
             + fftc_pkg::SUM_W'(fftc_pkg::RND);
    sum_im = fftc_pkg::SUM_W'(p_ir_r) + fftc_pkg::SUM_W'(p_ri_r)
             + fftc_pkg::SUM_W'(fftc_pkg::RND);
    t_re   = $signed(sum_re[fftc_pkg::SUM_W-1:fftc_pkg::FRAC_W]);
    t_im   = $signed(sum_im[fftc_pkg::SUM_W-1:fftc_pkg::FRAC_W]);
    a_re   = fftc_pkg::OUT_W'(a2_r.re);
    a_im   = fftc_pkg::OUT_W'(a2_r.im);
  end

  // Result register: the sums cannot overflow 18 bits.
  always_ff @(posedge clk) begin
    if (prod_v_r && res_rdy) begin
      top_re_r <= a_re + t_re;
      top_im_r <= a_im + t_im;
      bot_re_r <= a_re - t_re;
      bot_im_r <= a_im - t_im;
      tag3_r   <= tag2_r;
    end
  end

  assign out_valid      = res_v_r;
  assign out_top_re     = top_re_r;
  assign out_top_im     = top_im_r;
  assign out_bottom_re  = bot_re_r;
  assign out_bottom_im  = bot_im_r;
  assign out_pair_index = tag3_r.pair_index;
  assign out_group_end  = tag3_r.group_end;

endmodule

`default_nettype wire

// ===== design/fft_radix2_combine_stage.sv =====
// Channel   | Handshake                | Beat contents
// ----------+--------------------------+------------------------------------------
// input     | in_valid / in_stall      | mode, sample re/im, twiddle index/re/im
// result    | out_valid / out_stall    | top re/im, bottom re/im, pair index, end
// config    | cfg_wr_en                | half length (9 bits)
//
// Beats are taken every unstalled cycle; mode 1 and first-half beats give no result.
// A second-half beat passes three registers (store read, product, result) in order;
// its result is valid on the result channel once it reaches the result register.
// Reset leaves half length at 1 and expects the first half of a group next.
// A stalled result holds the pipeline; input is stalled only when every stage is full.
`default_nettype none
`include "assert_macros.svh"

module fft_radix2_combine_stage (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire  [fftc_pkg::LEN_W-1:0]           cfg_wr_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_mode,
  input  wire  signed [fftc_pkg::SMP_W-1:0]    in_sample_re,
  input  wire  signed [fftc_pkg::SMP_W-1:0]    in_sample_im,
  input  wire  [fftc_pkg::IDX_W-1:0]           in_twiddle_index,
  input  wire  signed [fftc_pkg::SMP_W-1:0]    in_twiddle_re,
  input  wire  signed [fftc_pkg::SMP_W-1:0]    in_twiddle_im,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_top_re,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_top_im,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_bottom_re,
  output logic signed [fftc_pkg::OUT_W-1:0]    out_bottom_im,
  output logic [fftc_pkg::IDX_W-1:0]           out_pair_index,
  output logic                                 out_group_end
);

  logic [fftc_pkg::LEN_W-1:0]  hl_r, hl_nxt;
  logic [fftc_pkg::LEN_W-1:0]  eff_len;
  logic [fftc_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  logic                        half_r, half_nxt;
  logic [fftc_pkg::IDX_W-1:0]  j;
  logic                        last;
  logic                        pos_ok;
  logic                        acc, acc_data, acc_pair, acc_fill, acc_tw, tw_idx_ok;
  logic                        v1_r, v1_nxt;
  logic                        bfly_rdy;
  fftc_pkg::mode_t             mode;
  fftc_pkg::cplx_t             smp;
  fftc_pkg::cplx_t             a1_r, b1_r, w1_r;
  fftc_pkg::tag_t              tag1_r;
  fftc_pkg::cplx_t             fh_mem [fftc_pkg::MAX_HALF];
  fftc_pkg::cplx_t             tw_mem [fftc_pkg::MAX_HALF];

  // Clamp the programmed half length into the supported range.
  always_comb begin
    if (hl_r == '0) begin
      eff_len = fftc_pkg::LEN_W'(1);
    end else if (hl_r > fftc_pkg::LEN_W'(fftc_pkg::MAX_HALF)) begin
      eff_len = fftc_pkg::LEN_W'(fftc_pkg::MAX_HALF);
    end else begin
      eff_len = hl_r;
    end
  end

  // Decode the incoming beat.
  always_comb begin
    mode      = fftc_pkg::mode_t'(in_mode);
    smp.re    = in_sample_re;
    smp.im    = in_sample_im;
    in_stall  = v1_r && !bfly_rdy;
    acc       = in_valid && !in_stall;
    acc_data  = acc && (mode == fftc_pkg::MODE_DATA);
    acc_tw    = acc && (mode == fftc_pkg::MODE_TWIDDLE);
    acc_fill  = acc_data && !half_r;
    acc_pair  = acc_data && half_r;
    tw_idx_ok = fftc_pkg::LEN_W'(in_twiddle_index) < fftc_pkg::LEN_W'(fftc_pkg::MAX_HALF);
    j         = (fftc_pkg::LEN_W'(pos_r) >= eff_len) ? '0 : pos_r;
    last      = (fftc_pkg::LEN_W'(j) + fftc_pkg::LEN_W'(1)) >= eff_len;
    pos_ok    = fftc_pkg::LEN_W'(pos_r) < eff_len;
  end

  // Group position: a length write restarts the group.
  always_comb begin
    hl_nxt   = hl_r;
    pos_nxt  = pos_r;
    half_nxt = half_r;
    if (cfg_wr_en) begin
      hl_nxt   = cfg_wr_data;
      pos_nxt  = '0;
      half_nxt = 1'b0;
    end else if (acc_data) begin
      pos_nxt  = last ? '0 : j + fftc_pkg::IDX_W'(1);
      half_nxt = last ? !half_r : half_r;
    end
  end

  // Store-read stage holds its beat until the butterfly takes it.
  assign v1_nxt = acc_pair ? 1'b1 : (bfly_rdy ? 1'b0 : v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r   <= fftc_pkg::LEN_W'(1);
      pos_r  <= '0;
      half_r <= 1'b0;
      v1_r   <= 1'b0;
    end else begin
      hl_r   <= hl_nxt;
      pos_r  <= pos_nxt;
      half_r <= half_nxt;
      v1_r   <= v1_nxt;
    end
  end

  // Delay store and twiddle table writes.
  always_ff @(posedge clk) begin
    if (acc_fill) begin
      fh_mem[j] <= smp;
    end
    if (acc_tw && tw_idx_ok) begin
      tw_mem[in_twiddle_index] <= '{re: in_twiddle_re, im: in_twiddle_im};
    end
  end

  // Registered reads of a[j] and w[j] alongside the second-half sample.
  always_ff @(posedge clk) begin
    if (acc_pair) begin
      a1_r              <= fh_mem[j];
      w1_r              <= tw_mem[j];
      b1_r              <= smp;
      tag1_r.pair_index <= j;
      tag1_r.group_end  <= last;
    end
  end

  fftc_bfly u_bfly (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (v1_r),
    .in_rdy         (bfly_rdy),
    .in_a           (a1_r),
    .in_b           (b1_r),
    .in_w           (w1_r),
    .in_tag         (tag1_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_top_re     (out_top_re),
    .out_top_im     (out_top_im),
    .out_bottom_re  (out_bottom_re),
    .out_bottom_im  (out_bottom_im),
    .out_pair_index (out_pair_index),
    .out_group_end  (out_group_end)
  );

  // The position always lies inside the current group half.
  `ASSERT_ALWAYS(a_pos_in_range, pos_ok, "position beyond half length")
  // A length write restarts the group at the first half.
  `ASSERT_NEXT(a_cfg_restart, cfg_wr_en, (!half_r && (pos_r == '0)), "length write did not restart")
  // The store-read stage fills only from an accepted second-half beat.
  `ASSERT_IMPL(a_v1_source, $rose(v1_r), $past(acc_pair), "pair stage loaded without a pair")

endmodule

`default_nettype wire

// ===== dv/fft_combine_checker.sv =====
// Watches both channels and the length register of the combine stage, predicts
// every butterfly and compares each result beat against the oldest prediction.
module fft_combine_checker
  import fftc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [LEN_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_mode,
  input  logic signed [SMP_W-1:0] in_sample_re,
  input  logic signed [SMP_W-1:0] in_sample_im,
  input  logic [IDX_W-1:0]        in_twiddle_index,
  input  logic signed [SMP_W-1:0] in_twiddle_re,
  input  logic signed [SMP_W-1:0] in_twiddle_im,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] out_top_re,
  input  logic signed [OUT_W-1:0] out_top_im,
  input  logic signed [OUT_W-1:0] out_bottom_re,
  input  logic signed [OUT_W-1:0] out_bottom_im,
  input  logic [IDX_W-1:0]        out_pair_index,
  input  logic                    out_group_end,
  output int                      mismatches,
  output int                      awaited,
  output int                      butterflies
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // One predicted butterfly, laid out like the result channel.
  typedef struct packed {
    logic signed [OUT_W-1:0] top_re;
    logic signed [OUT_W-1:0] top_im;
    logic signed [OUT_W-1:0] bottom_re;
    logic signed [OUT_W-1:0] bottom_im;
    tag_t                    tag;
  } butterfly_t;

  // Local copy of the block's state.
  cplx_t            first_half [MAX_HALF];
  cplx_t            twiddles   [MAX_HALF];
  int               position;
  bit               second_half;
  logic [LEN_W-1:0] half_len;
  butterfly_t       butterfly_q [$];

  // Product rounded to the nearest Q1.15 step, halves rounding up.
  function automatic longint round_q15(longint p);
    return (p + RND) >>> FRAC_W;
  endfunction

  // Rotates b by w and forms the sum and difference with a.
  function automatic butterfly_t combine_pair(cplx_t a, cplx_t b, cplx_t w, int j, int len);
    butterfly_t bf;
    longint     t_re;
    longint     t_im;
    t_re = round_q15(longint'(b.re) * longint'(w.re) - longint'(b.im) * longint'(w.im));
    t_im = round_q15(longint'(b.im) * longint'(w.re) + longint'(b.re) * longint'(w.im));
    bf.top_re            = OUT_W'(longint'(a.re) + t_re);
    bf.top_im            = OUT_W'(longint'(a.im) + t_im);
    bf.bottom_re         = OUT_W'(longint'(a.re) - t_re);
    bf.bottom_im         = OUT_W'(longint'(a.im) - t_im);
    bf.tag.pair_index    = IDX_W'(j);
    bf.tag.group_end     = (j + 1 >= len);
    return bf;
  endfunction

  function automatic string show(butterfly_t b);
    return $sformatf("top (%0d,%0d) bottom (%0d,%0d) pair %0d end %0b",
                     b.top_re, b.top_im, b.bottom_re, b.bottom_im,
                     b.tag.pair_index, b.tag.group_end);
  endfunction

  always @(posedge clk) begin
    cplx_t      smp;
    int         len;
    butterfly_t seen;
    butterfly_t want;
    if (!rst_n) begin
      half_len    = LEN_W'(1);
      position    = 0;
      second_half = 1'b0;
      mismatches  = 0;
      butterflies = 0;
      butterfly_q.delete();
    end else begin
      // A length write restarts the group at its first half.
      if (cfg_wr_en) begin
        half_len    = cfg_wr_data;
        position    = 0;
        second_half = 1'b0;
      end

      // Input beat: load a twiddle, store a first-half sample or predict a butterfly.
      if (in_valid && !in_stall) begin
        smp.re = in_sample_re;
        smp.im = in_sample_im;
        if (in_mode == MODE_TWIDDLE) begin
          twiddles[in_twiddle_index].re = in_twiddle_re;
          twiddles[in_twiddle_index].im = in_twiddle_im;
        end else begin
          len = (half_len == 0) ? 1 : ((half_len > MAX_HALF) ? MAX_HALF : int'(half_len));
          if (position >= len) begin
            position = 0;
          end
          if (!second_half) begin
            first_half[position] = smp;
          end else begin
            butterfly_q.push_back(combine_pair(first_half[position], smp,
                                               twiddles[position], position, len));
          end
          if (position + 1 >= len) begin
            position    = 0;
            second_half = !second_half;
          end else begin
            position++;
          end
        end
      end

      // Result beat: compare against the oldest prediction.
      if (out_valid && !out_stall) begin
        seen.top_re         = out_top_re;
        seen.top_im         = out_top_im;
        seen.bottom_re      = out_bottom_re;
        seen.bottom_im      = out_bottom_im;
        seen.tag.pair_index = out_pair_index;
        seen.tag.group_end  = out_group_end;
        if (butterfly_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("ERROR: result beat with nothing expected: %s", show(seen));
          end
        end else begin
          want = butterfly_q.pop_front();
          butterflies++;
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("ERROR: expected %s", show(want));
              $display("       got      %s", show(seen));
            end
          end
        end
      end
    end
    awaited = butterfly_q.size();
  end

endmodule

// ===== dv/tb_fft_radix2_combine_stage.sv =====
// Stimulus and verdict for the radix-2 combine stage; checking lives in
// fft_combine_checker.
module tb_fft_radix2_combine_stage;
  timeunit 1ns;
  timeprecision 1ps;
  import fftc_pkg::*;

  localparam int ITEMS_SMALL = 430;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN       = 8;
  localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SMP_W-1:0] S_HALF = 16'sh4000;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    cfg_wr_en        = 1'b0;
  logic [LEN_W-1:0]        cfg_wr_data      = '0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic                    in_mode          = MODE_DATA;
  logic signed [SMP_W-1:0] in_sample_re     = '0;
  logic signed [SMP_W-1:0] in_sample_im     = '0;
  logic [IDX_W-1:0]        in_twiddle_index = '0;
  logic signed [SMP_W-1:0] in_twiddle_re    = '0;
  logic signed [SMP_W-1:0] in_twiddle_im    = '0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic signed [OUT_W-1:0] out_top_re;
  logic signed [OUT_W-1:0] out_top_im;
  logic signed [OUT_W-1:0] out_bottom_re;
  logic signed [OUT_W-1:0] out_bottom_im;
  logic [IDX_W-1:0]        out_pair_index;
  logic                    out_group_end;

  int mismatches;
  int awaited;
  int butterflies;

  bit tw_loaded [MAX_HALF];
  int half_now      = 1;
  int beats         = 0;
  int twiddle_loads = 0;
  int settings      = 1;
  int cycles        = 0;
  int steady_left   = 0;
  int calm_left     = 0;
  int stall_left    = 0;

  fft_radix2_combine_stage dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_sample_re     (in_sample_re),
    .in_sample_im     (in_sample_im),
    .in_twiddle_index (in_twiddle_index),
    .in_twiddle_re    (in_twiddle_re),
    .in_twiddle_im    (in_twiddle_im),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_re       (out_top_re),
    .out_top_im       (out_top_im),
    .out_bottom_re    (out_bottom_re),
    .out_bottom_im    (out_bottom_im),
    .out_pair_index   (out_pair_index),
    .out_group_end    (out_group_end)
  );

  fft_combine_checker butterfly_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_sample_re     (in_sample_re),
    .in_sample_im     (in_sample_im),
    .in_twiddle_index (in_twiddle_index),
    .in_twiddle_re    (in_twiddle_re),
    .in_twiddle_im    (in_twiddle_im),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_re       (out_top_re),
    .out_top_im       (out_top_im),
    .out_bottom_re    (out_bottom_re),
    .out_bottom_im    (out_bottom_im),
    .out_pair_index   (out_pair_index),
    .out_group_end    (out_group_end),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .butterflies      (butterflies)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d butterflies outstanding.", cycles, awaited);
      $display("FAIL");
      $finish;
    end
  end

  // Result-side back-pressure: calm stretches, short stalls and the odd long one.
  always @(negedge clk) begin
    int r;
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        calm_left = $urandom_range(20, 120);
      end else if (r < 5) begin
        stall_left = $urandom_range(8, 40);
      end else if (r < 30) begin
        stall_left = $urandom_range(0, 2);
      end
      out_stall <= (r >= 2 && r < 30);
    end
  end

  // Sender gap before the next beat: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 6) return $urandom_range(8, 30);
    if (r < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Random part value with a bias towards the two extremes.
  function automatic logic signed [SMP_W-1:0] edgy_part();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return S_MIN;
    if (r == 1) return S_MAX;
    return SMP_W'($urandom);
  endfunction

  function automatic cplx_t rand_cplx();
    cplx_t c;
    c.re = edgy_part();
    c.im = edgy_part();
    return c;
  endfunction

  // Presents one beat at a falling edge and holds it until it is taken.
  task automatic send_beat(input mode_t mode, input cplx_t smp, input logic [IDX_W-1:0] idx,
                           input cplx_t tw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_sample_re     <= smp.re;
    in_sample_im     <= smp.im;
    in_twiddle_index <= idx;
    in_twiddle_re    <= tw.re;
    in_twiddle_im    <= tw.im;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats++;
  endtask

  task automatic send_twiddle(input logic [IDX_W-1:0] idx, input cplx_t w);
    send_beat(MODE_TWIDDLE, rand_cplx(), idx, w);
    tw_loaded[idx] = 1'b1;
    twiddle_loads++;
  endtask

  task automatic send_sample(input cplx_t s);
    send_beat(MODE_DATA, s, IDX_W'($urandom), rand_cplx());
  endtask

  // Length writes happen only once the pipeline has drained.
  task automatic write_length(input logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    half_now = (value == 0) ? 1 : ((value > MAX_HALF) ? MAX_HALF : int'(value));
    settings++;
  endtask

  // Every twiddle that a group of the current length reads must be loaded first.
  task automatic ensure_twiddles();
    for (int i = 0; i < half_now; i++) begin
      if (!tw_loaded[i]) begin
        send_twiddle(IDX_W'(i), rand_cplx());
      end
    end
  endtask

  // Whole groups with the odd stray twiddle load, then an optional broken tail.
  task automatic run_groups(input int groups, input int tail);
    for (int g = 0; g < groups; g++) begin
      for (int k = 0; k < 2 * half_now; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_twiddle(IDX_W'($urandom), rand_cplx());
        end
        send_sample(rand_cplx());
      end
    end
    for (int k = 0; k < tail; k++) begin
      send_sample(rand_cplx());
    end
  endtask

  initial begin
    int r;
    int len;
    int small_start;
    int groups;
    int tail;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset length of one, extreme values and rounding of halves.
    send_twiddle(8'd0, cplx_t'{re: S_MIN, im: S_MIN});
    send_twiddle(8'd255, cplx_t'{re: S_MAX, im: S_MAX});
    send_sample(cplx_t'{re: S_MAX, im: S_MIN});
    send_sample(cplx_t'{re: S_MIN, im: S_MIN});
    send_twiddle(8'd0, cplx_t'{re: S_MAX, im: S_MIN});
    send_sample(cplx_t'{re: S_MIN, im: S_MAX});
    send_sample(cplx_t'{re: S_MAX, im: S_MAX});
    send_twiddle(8'd0, cplx_t'{re: S_HALF, im: 16'sd0});
    send_sample(cplx_t'{re: 16'sd0, im: 16'sd0});
    send_sample(cplx_t'{re: 16'sd1, im: -16'sd1});
    send_twiddle(8'd0, cplx_t'{re: S_MIN, im: S_MAX});
    send_sample(cplx_t'{re: S_MAX, im: S_MAX});
    send_sample(cplx_t'{re: S_MIN, im: S_MIN});

    // A length of zero behaves as one.
    write_length('0);
    run_groups(1, 0);

    // Rewriting the length after a first half restarts the group.
    write_length(LEN_W'(4));
    ensure_twiddles();
    run_groups(0, 4);
    write_length(LEN_W'(2));
    run_groups(2, 0);

    // Largest lengths: one clamped full group, then broken runs at the top values.
    write_length(LEN_W'(511));
    ensure_twiddles();
    run_groups(1, 0);
    write_length(LEN_W'(256));
    run_groups(0, 40);
    write_length(LEN_W'(257));
    run_groups(0, 20);

    // Random phases, mostly short lengths and well-formed groups.
    small_start = beats;
    while (beats - small_start < ITEMS_SMALL) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        len = 0;
      end else if (r < 12) begin
        len = $urandom_range(17, 64);
      end else begin
        len = $urandom_range(1, 16);
      end
      write_length(LEN_W'(len));
      ensure_twiddles();
      groups = $urandom_range(1, (half_now > 16) ? 2 : 6);
      tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * half_now - 1) : 0;
      run_groups(groups, tail);
    end

    // Drain, then the verdict.
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Drove %0d input beats (%0d twiddle loads) across %0d length settings.",
             beats, twiddle_loads, settings);
    $display("Compared %0d butterflies; %0d mismatched or unexpected, %0d never arrived.",
             butterflies, mismatches, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
